@@ rtl/aipb_pkg.sv @@
// ============================================================================
// aipb_pkg: shared types and constants for the idle poll backoff unit
// Event kinds, action codes, register indexes and ladder timing constants.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package aipb_pkg;

   // event kinds carried in req_tuser
   localparam logic [1:0] CMD_DRAIN  = 2'd0;
   localparam logic [1:0] CMD_POLL   = 2'd1;
   localparam logic [1:0] CMD_RESUME = 2'd2;

   // actions carried in rsp_tuser
   localparam logic [1:0] ACT_YIELD  = 2'd0;
   localparam logic [1:0] ACT_SLEEP  = 2'd1;
   localparam logic [1:0] ACT_NOWAIT = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_PLATEAU_MAX = 3'd0;
   localparam logic [2:0] REG_PLATEAU_MIN = 3'd1;
   localparam logic [2:0] REG_LONG_IDLE   = 3'd2;
   localparam logic [2:0] REG_WINDOW      = 3'd3;
   localparam logic [2:0] REG_PERCENT     = 3'd4;

   // ladder timing
   localparam logic [15:0] YIELD_POLLS      = 16'd16;
   localparam logic [15:0] POLL_COUNT_MAX   = 16'hFFFF;
   localparam logic [9:0]  FIRST_SLEEP_US   = 10'd10;
   localparam logic [9:0]  PLATEAU_SLEEP_US = 10'd40;
   localparam logic [9:0]  DEEP_SLEEP_US    = 10'd640;

   // window evaluation
   localparam logic [6:0]  PERCENT_FULL   = 7'd100;

   // register reset values
   localparam logic [7:0]  RST_PLATEAU_MAX = 8'd16;
   localparam logic [7:0]  RST_PLATEAU_MIN = 8'd2;
   localparam logic [47:0] RST_LONG_IDLE   = 48'd2000000;
   localparam logic [47:0] RST_WINDOW      = 48'd200000000;
   localparam logic [6:0]  RST_PERCENT     = 7'd50;

   // ladder decision for one idle poll
   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  sleep_us;
      logic [15:0] poll_count;
   } ladder_type;

endpackage

`default_nettype wire

@@ rtl/aipb_ladder.sv @@
// ============================================================================
// aipb_ladder: idle poll backoff ladder
// Bumps the saturating poll count and picks yield, short, warm or deep sleep.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module aipb_ladder
   import aipb_pkg::*;
(
   input  wire logic [15:0] poll_count,
   input  wire logic [7:0]  plateau_depth,
   output ladder_type       decision
);

   logic [15:0] count_next;
   logic [15:0] rung;

   // saturate the count at its ceiling
   assign count_next = (poll_count == POLL_COUNT_MAX) ? poll_count : poll_count + 16'd1;
   assign rung       = count_next - YIELD_POLLS;

   // yield first, then climb the sleep ladder
   always_comb begin
      decision.poll_count = count_next;
      decision.action     = ACT_SLEEP;
      decision.sleep_us   = DEEP_SLEEP_US;
      priority if (count_next < YIELD_POLLS) begin
         decision.action   = ACT_YIELD;
         decision.sleep_us = 10'd0;
      end else if (rung < {8'd0, plateau_depth}) begin
         decision.sleep_us = (rung == 16'd0) ? FIRST_SLEEP_US : PLATEAU_SLEEP_US;
      end else begin
         decision.sleep_us = DEEP_SLEEP_US;
      end
   end

endmodule

`default_nettype wire

@@ rtl/adaptive_idle_poll_backoff_unit.sv @@
// ============================================================================
// adaptive_idle_poll_backoff_unit: event driven idle poll backoff controller
// Tracks long idle gaps between drains, selects coarse or responsive mode and
// paces idle polls with a yield / sleep ladder.
// ============================================================================
// Usage:
//   req channel: one word per event; req_tuser holds the event kind
//   (drain, idle poll, resume), req_tdata the 64-bit timestamp in ns.
//   rsp channel: one word per event, in order; rsp_tuser holds the action,
//   rsp_tdata the sleep length, the plateau depth and the coarse flag.
//   csr port: write csr_we with csr_index and csr_wdata; writes take effect
//   at once; the user must issue them only while no event is in flight (not enforced).
//   Path: an accepted event passes the input register, then the result register,
//   before rsp_tvalid rises. Throughput: one event per cycle while the result
//   register drains; window evaluation and ladder step run in the single compute stage.
//   Stall: while rsp_tready is low the result register holds and the input
//   register fills; req_tready drops once both are occupied.
//   Reset: synchronous; clears both stages, restores register defaults and
//   returns the tracker to unanchored responsive mode.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adaptive_idle_poll_backoff_unit
   import aipb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // event channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] now_ns
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [9:0] sleep_us, [17:10] plateau_depth_out,
                                         // [18] coarse_out, [23:19] zero
   output      logic [1:0]  rsp_tuser,   // [1:0] action
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   // configuration registers
   logic [7:0]  plateau_max_ff;
   logic [7:0]  plateau_min_ff;
   logic [47:0] long_idle_ff;
   logic [47:0] window_ff;
   logic [6:0]  percent_ff;

   // input stage
   logic        in_valid_ff;
   logic [1:0]  in_cmd_ff;
   logic [63:0] in_now_ff;

   // tracker state
   logic [15:0] poll_count_ff,  poll_count_in;
   logic [63:0] last_drain_ff,  last_drain_in;
   logic [63:0] win_start_ff,   win_start_in;
   logic [63:0] idle_total_ff,  idle_total_in;
   logic        coarse_ff,      coarse_in;
   logic        anchored_ff,    anchored_in;
   logic [7:0]  depth_ff,       depth_in;

   // result stage
   logic        out_valid_ff;
   logic [1:0]  out_action_ff,  out_action_in;
   logic [9:0]  out_sleep_ff,   out_sleep_in;
   logic [7:0]  out_depth_ff;
   logic        out_coarse_ff;

   logic        advance;
   logic        fire;

   // drain evaluation
   logic [63:0] gap;
   logic [63:0] total_acc;
   logic [63:0] start_eff;
   logic [63:0] elapsed;
   logic [6:0]  pct;
   logic [63:0] idle_scaled;
   logic [63:0] window_scaled;
   logic        coarse_eval;

   ladder_type  ladder;

   // handshake: result register drains or is empty, input register follows
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plateau_max_ff <= RST_PLATEAU_MAX;
         plateau_min_ff <= RST_PLATEAU_MIN;
         long_idle_ff   <= RST_LONG_IDLE;
         window_ff      <= RST_WINDOW;
         percent_ff     <= RST_PERCENT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PLATEAU_MAX: plateau_max_ff <= csr_wdata[7:0];
            REG_PLATEAU_MIN: plateau_min_ff <= csr_wdata[7:0];
            REG_LONG_IDLE:   long_idle_ff   <= csr_wdata;
            REG_WINDOW:      window_ff      <= csr_wdata;
            REG_PERCENT:     percent_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // capture the incoming event word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_now_ff <= req_tdata;
      end
   end

   // long idle accumulation and window check for a drain
   assign gap       = in_now_ff - last_drain_ff;
   assign total_acc = (anchored_ff && (gap >= {16'd0, long_idle_ff}))
                      ? idle_total_ff + gap : idle_total_ff;
   assign start_eff = anchored_ff ? win_start_ff : in_now_ff;
   assign elapsed   = in_now_ff - start_eff;
   assign pct       = (percent_ff > PERCENT_FULL) ? PERCENT_FULL : percent_ff;

   // both products wrap at 64 bits
   assign idle_scaled   = total_acc * {57'd0, PERCENT_FULL};
   assign window_scaled = elapsed * {57'd0, pct};
   assign coarse_eval   = idle_scaled >= window_scaled;

   aipb_ladder u_ladder (
      .poll_count    (poll_count_ff),
      .plateau_depth (depth_ff),
      .decision      (ladder)
   );

   // next tracker state and result
   always_comb begin
      poll_count_in = poll_count_ff;
      last_drain_in = last_drain_ff;
      win_start_in  = win_start_ff;
      idle_total_in = idle_total_ff;
      coarse_in     = coarse_ff;
      anchored_in   = anchored_ff;
      depth_in      = depth_ff;
      out_action_in = ACT_NOWAIT;
      out_sleep_in  = 10'd0;
      unique case (in_cmd_ff)
         CMD_DRAIN: begin
            anchored_in   = 1'b1;
            last_drain_in = in_now_ff;
            poll_count_in = 16'd0;
            if (elapsed >= {16'd0, window_ff}) begin
               coarse_in     = coarse_eval;
               win_start_in  = in_now_ff;
               idle_total_in = 64'd0;
            end else begin
               win_start_in  = start_eff;
               idle_total_in = total_acc;
            end
            depth_in = coarse_in ? plateau_min_ff : plateau_max_ff;
         end
         CMD_POLL: begin
            poll_count_in = ladder.poll_count;
            out_action_in = ladder.action;
            out_sleep_in  = ladder.sleep_us;
         end
         CMD_RESUME: begin
            poll_count_in = 16'd0;
         end
         default: ;
      endcase
   end

   // update tracker state on each processed event
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_count_ff <= 16'd0;
         last_drain_ff <= 64'd0;
         win_start_ff  <= 64'd0;
         idle_total_ff <= 64'd0;
         coarse_ff     <= 1'b0;
         anchored_ff   <= 1'b0;
         depth_ff      <= RST_PLATEAU_MAX;
      end else if (fire) begin
         poll_count_ff <= poll_count_in;
         last_drain_ff <= last_drain_in;
         win_start_ff  <= win_start_in;
         idle_total_ff <= idle_total_in;
         coarse_ff     <= coarse_in;
         anchored_ff   <= anchored_in;
         depth_ff      <= depth_in;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_action_ff <= out_action_in;
         out_sleep_ff  <= out_sleep_in;
         out_depth_ff  <= depth_in;
         out_coarse_ff <= coarse_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tdata  = {5'd0, out_coarse_ff, out_depth_ff, out_sleep_ff};

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for adaptive_idle_poll_backoff_unit
// Drives drain, idle poll and resume events over the req stream, predicts
// every rsp word with a cycle-free model of the backoff tracker and compares
// the words in order. A short directed table comes first; randomized traffic
// under several register settings, long receiver hold-offs and a
// back-to-back poll run follow.
// ============================================================================

module tb;
   import aipb_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES = 64;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_EVENTS = 230;
   localparam int TAIL_POLLS = 60;

   // one result word as the block reports it
   typedef struct packed {
      logic [1:0] action;
      logic [9:0] sleep_us;
      logic [7:0] depth;
      logic       coarse;
   } backoff_word_type;

   // one row of the directed table
   typedef struct packed {
      logic [1:0]       cmd;
      logic [63:0]      now;
      logic             typed;
      backoff_word_type want;
   } event_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] now_ns
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [9:0] sleep_us, [17:10] plateau_depth_out,
                                  // [18] coarse_out, [23:19] zero
   logic [1:0]  rsp_tuser;        // [1:0] action
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   adaptive_idle_poll_backoff_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // tracker registers and state mirrored by the predictor
   logic [7:0]  cfg_plateau_max;
   logic [7:0]  cfg_plateau_min;
   logic [47:0] cfg_long_idle;
   logic [47:0] cfg_window;
   logic [6:0]  cfg_percent;
   logic [15:0] trk_poll_count;
   logic [63:0] trk_last_drain;
   logic [63:0] trk_window_start;
   logic [63:0] trk_idle_total;
   logic        trk_coarse;
   logic        trk_anchored;
   logic [7:0]  trk_depth;

   backoff_word_type pending_words[$];
   event_row_type    directed_rows[12];
   logic [63:0]      drain_clock;
   bit               quiet = 1'b0;
   bit               long_hold = 1'b0;
   int               events_sent = 0;
   int               words_checked = 0;
   int               mismatches = 0;
   int               windows_closed = 0;
   int               deep_sleeps = 0;
   int               coarse_words = 0;
   int               holds_done = 0;
   int               idle_cycles = 0;

   // restore register defaults and an unanchored responsive tracker
   task automatic reset_tracker();
      cfg_plateau_max = RST_PLATEAU_MAX;
      cfg_plateau_min = RST_PLATEAU_MIN;
      cfg_long_idle = RST_LONG_IDLE;
      cfg_window = RST_WINDOW;
      cfg_percent = RST_PERCENT;
      trk_poll_count = '0;
      trk_last_drain = '0;
      trk_window_start = '0;
      trk_idle_total = '0;
      trk_coarse = 1'b0;
      trk_anchored = 1'b0;
      trk_depth = RST_PLATEAU_MAX;
   endtask

   // advance the tracker by one event and return the word it answers with
   function automatic backoff_word_type step_backoff(input logic [1:0] cmd,
                                                     input logic [63:0] now);
      backoff_word_type word;
      logic [63:0]      gap;
      logic [63:0]      elapsed;
      logic [63:0]      share;
      logic [15:0]      rung;
      word.action = ACT_NOWAIT;
      word.sleep_us = '0;
      case (cmd)
         CMD_DRAIN: begin
            share = (cfg_percent > PERCENT_FULL) ? 64'(PERCENT_FULL) : 64'(cfg_percent);
            if (trk_anchored) begin
               gap = now - trk_last_drain;
               if (gap >= 64'(cfg_long_idle))
                  trk_idle_total = trk_idle_total + gap;
            end else begin
               trk_window_start = now;
               trk_anchored = 1'b1;
            end
            trk_last_drain = now;
            elapsed = now - trk_window_start;
            // close the window: both products wrap at 64 bits
            if (elapsed >= 64'(cfg_window)) begin
               trk_coarse = (trk_idle_total * 64'(PERCENT_FULL)) >= (elapsed * share);
               trk_window_start = now;
               trk_idle_total = '0;
               windows_closed++;
            end
            trk_depth = trk_coarse ? cfg_plateau_min : cfg_plateau_max;
            trk_poll_count = '0;
         end
         CMD_POLL: begin
            if (trk_poll_count != POLL_COUNT_MAX)
               trk_poll_count = trk_poll_count + 16'd1;
            if (trk_poll_count < YIELD_POLLS) begin
               word.action = ACT_YIELD;
            end else begin
               rung = trk_poll_count - YIELD_POLLS;
               word.action = ACT_SLEEP;
               if (rung < {8'd0, trk_depth}) begin
                  word.sleep_us = (rung == 16'd0) ? FIRST_SLEEP_US : PLATEAU_SLEEP_US;
               end else begin
                  word.sleep_us = DEEP_SLEEP_US;
                  deep_sleeps++;
               end
            end
         end
         CMD_RESUME: trk_poll_count = '0;
         default: ;
      endcase
      word.depth = trk_depth;
      word.coarse = trk_coarse;
      return word;
   endfunction

   // offer one event, hold it until accepted, then queue its expected word
   task automatic send_event(input logic [1:0] cmd, input logic [63:0] now,
                             input logic typed, input backoff_word_type want);
      backoff_word_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= now;
      do @(posedge clock); while (!req_tready);
      predicted = step_backoff(cmd, now);
      pending_words.push_back(typed ? want : predicted);
      events_sent++;
   endtask

   task automatic send_plain(input logic [1:0] cmd, input logic [63:0] now);
      send_event(cmd, now, 1'b0, '0);
   endtask

   // drop valid and wait for every outstanding word
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [47:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_PLATEAU_MAX: cfg_plateau_max = value[7:0];
         REG_PLATEAU_MIN: cfg_plateau_min = value[7:0];
         REG_LONG_IDLE:   cfg_long_idle = value;
         REG_WINDOW:      cfg_window = value;
         REG_PERCENT:     cfg_percent = value[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] pmax, input logic [7:0] pmin,
                             input logic [47:0] idle_ns, input logic [47:0] win_ns,
                             input logic [47:0] percent);
      write_reg(REG_PLATEAU_MAX,
                48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FF00 | 48'(pmax));
      write_reg(REG_PLATEAU_MIN, 48'(pmin));
      write_reg(REG_LONG_IDLE, idle_ns);
      write_reg(REG_WINDOW, win_ns);
      write_reg(REG_PERCENT, percent);
      // unused indexes must leave everything alone
      write_reg(REG_UNUSED_LO, 48'({$urandom, $urandom}));
      write_reg(REG_UNUSED_HI, 48'hFFFF_FFFF_FFFF);
   endtask

   function automatic logic [31:0] clip32(input logic [63:0] value);
      return (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
   endfunction

   // pick a drain-to-drain gap around the long idle threshold and the window
   function automatic logic [63:0] next_gap();
      logic [63:0] idle_ns;
      idle_ns = 64'(cfg_long_idle);
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, clip32(idle_ns)));
         1: return (idle_ns == 0) ? 64'd0 : idle_ns - 64'($urandom_range(0, 1));
         2: return idle_ns + 64'($urandom_range(0, clip32(64'(cfg_window) + 4)));
         default: return 64'($urandom_range(0, clip32(64'(cfg_window) / 4 + 8)));
      endcase
   endfunction

   // mostly drain-then-poll sequences with random content, some noise events
   task automatic random_traffic(input int count);
      int target;
      int run;
      target = events_sent + count;
      while (events_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            drain_clock = drain_clock + next_gap();
            send_plain(CMD_DRAIN, drain_clock);
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(trk_depth) + 24)
                                              : $urandom_range(0, 24);
            repeat (run) send_plain(CMD_POLL, {$urandom, $urandom});
            if ($urandom_range(0, 2) == 0) begin
               send_plain(CMD_RESUME, {$urandom, $urandom});
               repeat ($urandom_range(0, 20)) send_plain(CMD_POLL, {$urandom, $urandom});
            end
         end else begin
            send_plain(2'($urandom_range(0, 3)), {$urandom, $urandom});
         end
      end
   endtask

   // receiver: short random stalls, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
            holds_done++;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      backoff_word_type got;
      backoff_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[9:0], rsp_tdata[17:10], rsp_tdata[18]};
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: action %0d sleep %0d depth %0d coarse %0d",
                        got.action, got.sleep_us, got.depth, got.coarse);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (got.coarse)
               coarse_words++;
            if (got !== want || rsp_tdata[23:19] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on word %0d: expected action %0d sleep %0d depth %0d coarse %0d",
                           words_checked, want.action, want.sleep_us, want.depth,
                           want.coarse);
                  $display("   got action %0d sleep %0d depth %0d coarse %0d pad %0h",
                           got.action, got.sleep_us, got.depth, got.coarse,
                           rsp_tdata[23:19]);
               end
            end
         end
      end
   end

   // watchdog: count cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles, %0d words outstanding",
                  idle_cycles, pending_words.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset_tracker();
      drain_clock = '0;
      directed_rows = '{
         '{CMD_POLL,   64'd0, 1'b1, '{ACT_YIELD,  10'd0, RST_PLATEAU_MAX, 1'b0}},
         '{CMD_RESUME, 64'd0, 1'b1, '{ACT_NOWAIT, 10'd0, RST_PLATEAU_MAX, 1'b0}},
         '{CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{ACT_NOWAIT, 10'd0, RST_PLATEAU_MAX, 1'b0}},
         // first drain at time zero anchors the window
         '{CMD_DRAIN,  64'd0, 1'b1, '{ACT_NOWAIT, 10'd0, RST_PLATEAU_MAX, 1'b0}},
         '{CMD_POLL,   64'd0, 1'b1, '{ACT_YIELD,  10'd0, RST_PLATEAU_MAX, 1'b0}},
         // full-range gap: both products wrap
         '{CMD_DRAIN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
         // timestamp wraps past zero
         '{CMD_DRAIN,  64'd5, 1'b0, '0},
         // long idle gap closes the window into coarse mode
         '{CMD_DRAIN,  64'd300_000_005, 1'b0, '0},
         '{CMD_POLL,   64'h5555_5555_5555_5555, 1'b0, '0},
         '{CMD_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
         '{CMD_DRAIN,  64'd300_001_005, 1'b0, '0},
         '{CMD_RESUME, 64'd0, 1'b0, '0}
      };

      // hold reset, then release it on a falling clock edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at register defaults
      foreach (directed_rows[i])
         send_event(directed_rows[i].cmd, directed_rows[i].now,
                    directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // short window, half share threshold
      set_config(8'd4, 8'd1, 48'd50, 48'd400, 48'd50);
      drain_clock = 64'd1000;
      random_traffic(RANDOM_EVENTS);
      drain_results();

      // zero window, zero threshold, zero share: every drain goes coarse
      set_config(8'd255, 8'd0, 48'd0, 48'd0, 48'd0);
      long_hold = 1'b1;
      random_traffic(RANDOM_EVENTS);
      drain_results();

      // widest threshold and window, share above full clamps to full
      set_config(8'd0, 8'd255, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd127);
      drain_clock = 64'hFFFF_FFFF_FFFF_0000;
      random_traffic(RANDOM_EVENTS);
      drain_results();

      // random moderate settings
      set_config(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                 48'($urandom_range(20, 200)), 48'($urandom_range(200, 2000)),
                 48'($urandom_range(0, 127)));
      random_traffic(RANDOM_EVENTS);
      drain_results();

      set_config(8'd8, 8'd3, 48'd100, 48'd1000, 48'd100);
      long_hold = 1'b1;
      random_traffic(RANDOM_EVENTS);
      drain_results();

      // back-to-back tail: climb the ladder into deep sleep
      quiet = 1'b1;
      drain_clock = drain_clock + 64'd5000;
      send_plain(CMD_DRAIN, drain_clock);
      repeat (TAIL_POLLS) send_plain(CMD_POLL, {$urandom, $urandom});
      random_traffic(40);
      drain_results();
      repeat (8) @(posedge clock);

      $display("covered %0d events, %0d words checked, %0d windows closed, %0d coarse words",
               events_sent, words_checked, windows_closed, coarse_words);
      $display("ladder reached 640 us sleep %0d times, %0d long holds",
               deep_sleeps, holds_done);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d words never arrived", mismatches, pending_words.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/aipb_pkg.sv
rtl/aipb_ladder.sv
rtl/adaptive_idle_poll_backoff_unit.sv
test/tb.sv
